FILE: rtl/core/malg_pkg.sv
// Package for the multi-ant Langton generation engine.
// Holds sizes, action and status codes, sequencer states and small helpers.
// No dependencies.
package malg_pkg;

  localparam int GridMax   = 64;
  localparam int MaxAnts   = 16;
  localparam int CoordW    = $clog2(GridMax);
  localparam int CellAw    = 2 * CoordW;
  localparam int CellNum   = GridMax * GridMax;
  localparam int AntIdxW   = $clog2(MaxAnts);
  localparam int AntCntW   = $clog2(MaxAnts + 1);
  localparam int SideW     = 7;
  localparam int InDataW   = 24;
  localparam int OutDataW  = 24;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 7;

  typedef enum logic [2:0] {
    ACT_PLACE    = 3'd0,
    ACT_GEN      = 3'd1,
    ACT_RD_CELL  = 3'd2,
    ACT_RD_ANT   = 3'd3,
    ACT_CLEAR    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_INDEX     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_GRID_SIZE = 2'd0,
    CFG_TORUS     = 2'd1,
    CFG_POLICY    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    POL_ODD    = 2'd0,
    POL_SINGLE = 2'd1,
    POL_ANY    = 2'd2
  } policy_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL,
    S_CELL_D,
    S_G_RD,
    S_G_UPD,
    S_G_FLIP,
    S_REPLY
  } state_e;

  typedef struct packed {
    logic [1:0]        status;
    logic              cell_black;
    logic [CoordW-1:0] ant_row;
    logic [CoordW-1:0] ant_col;
    logic [1:0]        ant_heading;
    logic [AntCntW-1:0] live_ants;
  } result_t;

  function automatic logic flip_wanted(input logic [1:0] policy,
                                       input logic [AntCntW-1:0] touches);
    logic res;
    unique case (policy)
      POL_SINGLE: res = (touches == AntCntW'(1));
      POL_ANY:    res = (touches != '0);
      default:    res = touches[0];
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/multi_ant_langton_generation.sv
// Top level of the multi-ant Langton generation engine.
// Depends on malg_pkg; holds the cell memory, ant table and sequencer.
//
// One request goes in, one reply comes out. After reset, and after a clear
// request, the block sweeps the 4096-cell memory one cell a cycle and takes
// no request meanwhile; configuration writes are taken at any time. Place and
// read-ant go straight to the reply; read-cell passes S_CELL and S_CELL_D.
// In a generation, per live ant S_G_RD reads its cell from the memory and
// S_G_UPD turns, moves and compacts it, and a final S_G_FLIP sweep writes back
// the flipped cells. Touches per cell are counted by comparing each ant's
// start cell against all others at once, so only the first ant on a cell
// decides its flip. The memory's one read and one write port set this order
// of steps. A finished reply sits in an output register, and the next
// request is taken while it waits.
module multi_ant_langton_generation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // action[2:0], row[8:3], col[14:9], heading[16:15], ant_index[20:17]
  input  logic [malg_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[1:0], cell_black[2], ant_row[8:3], ant_col[14:9],
  // ant_heading[16:15], live_ants[21:17]
  output logic [malg_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [malg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [malg_pkg::CfgDataW-1:0] cfg_data_i
);
  import malg_pkg::*;

  // configuration
  logic [SideW-1:0] grid_size_q;
  logic             torus_q;
  logic [1:0]       policy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= SideW'(GridMax);
      torus_q     <= 1'b1;
      policy_q    <= POL_ODD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_SIZE: grid_size_q <= cfg_data_i;
        CFG_TORUS:     torus_q     <= cfg_data_i[0];
        CFG_POLICY:    policy_q    <= cfg_data_i[1:0];
        default:       ;
      endcase
    end
  end

  logic [SideW-1:0] side;
  always_comb begin
    if (grid_size_q == '0)                 side = SideW'(1);
    else if (grid_size_q > SideW'(GridMax)) side = SideW'(GridMax);
    else                                   side = grid_size_q;
  end

  // request fields
  logic [2:0]         in_action;
  logic [CoordW-1:0]  in_row, in_col;
  logic [1:0]         in_heading;
  logic [AntIdxW-1:0] in_index;
  assign in_action  = s_axis_tdata[2:0];
  assign in_row     = s_axis_tdata[8:3];
  assign in_col     = s_axis_tdata[14:9];
  assign in_heading = s_axis_tdata[16:15];
  assign in_index   = s_axis_tdata[20:17];

  // cell memory, one write and one registered read per cycle
  logic              grid_mem [CellNum];
  logic [CellAw-1:0] rd_addr, wr_addr;
  logic              wr_en, wr_data, rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) grid_mem[wr_addr] <= wr_data;
    rd_data_q <= grid_mem[rd_addr];
  end

  // ant table and per-generation scratch
  logic [CoordW-1:0] ant_row_q  [MaxAnts];
  logic [CoordW-1:0] ant_col_q  [MaxAnts];
  logic [1:0]        ant_head_q [MaxAnts];
  logic [CellAw-1:0] snap_q     [MaxAnts];
  logic              flip_q     [MaxAnts];
  logic              color_q    [MaxAnts];
  logic [AntCntW-1:0] live_q, gen_cnt_q, kept_q;
  logic [AntIdxW-1:0] ant_i_q;

  state_e            state_q, state_d;
  logic [CellAw-1:0] clr_cnt_q;
  logic              clr_reply_q;
  logic [CoordW-1:0] req_row_q, req_col_q;
  result_t           res_q;
  result_t           out_q;
  logic              out_valid_q;

  logic acc, out_free, ant_last, clr_last;
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign ant_last = ({1'b0, ant_i_q} == gen_cnt_q - AntCntW'(1));
  assign clr_last = (clr_cnt_q == '1);
  assign s_axis_tready = (state_q == S_IDLE);

  // touch count for the current ant's start cell, and whether it is first there
  logic [MaxAnts-1:0] match;
  logic [AntCntW-1:0] touches;
  logic               first_here;
  always_comb begin
    for (int k = 0; k < MaxAnts; k++) begin
      match[k] = (AntCntW'(k) < gen_cnt_q) && (snap_q[k] == snap_q[ant_i_q]);
    end
    touches    = AntCntW'($countones(match));
    first_here = 1'b1;
    for (int k = 0; k < MaxAnts; k++) begin
      if (match[k] && (AntIdxW'(k) < ant_i_q)) first_here = 1'b0;
    end
  end

  // turn and move of the current ant
  logic [1:0]       new_head;
  logic [SideW-1:0] nrow, ncol;
  logic             under, alive;
  always_comb begin
    new_head = rd_data_q ? ant_head_q[ant_i_q] - 2'd1 : ant_head_q[ant_i_q] + 2'd1;
    nrow  = {1'b0, ant_row_q[ant_i_q]};
    ncol  = {1'b0, ant_col_q[ant_i_q]};
    under = 1'b0;
    unique case (new_head)
      2'd0: if (nrow == '0) under = 1'b1; else nrow = nrow - SideW'(1);
      2'd1: ncol = ncol + SideW'(1);
      2'd2: nrow = nrow + SideW'(1);
      default: if (ncol == '0) under = 1'b1; else ncol = ncol - SideW'(1);
    endcase
    alive = 1'b1;
    if (torus_q) begin
      if (under && new_head == 2'd0) nrow = side - SideW'(1);
      else if (nrow >= side)         nrow = '0;
      if (under && new_head == 2'd3) ncol = side - SideW'(1);
      else if (ncol >= side)         ncol = '0;
    end else if (under || nrow >= side || ncol >= side) begin
      alive = 1'b0;
    end
  end

  // memory port steering
  always_comb begin
    rd_addr = snap_q[ant_i_q];
    wr_en   = 1'b0;
    wr_addr = snap_q[ant_i_q];
    wr_data = !color_q[ant_i_q];
    unique case (state_q)
      S_CELL:   rd_addr = {req_row_q, req_col_q};
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
        wr_data = 1'b0;
      end
      S_G_FLIP: wr_en = flip_q[ant_i_q];
      default:  ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (clr_last) state_d = clr_reply_q ? S_REPLY : S_IDLE;
      S_IDLE: begin
        if (acc) begin
          unique case (in_action)
            ACT_GEN:     state_d = (live_q == '0) ? S_REPLY : S_G_RD;
            ACT_RD_CELL: state_d = (in_row >= side || in_col >= side) ? S_REPLY : S_CELL;
            ACT_CLEAR:   state_d = S_CLEAR;
            default:     state_d = S_REPLY;
          endcase
        end
      end
      S_CELL:   state_d = S_CELL_D;
      S_CELL_D: state_d = S_REPLY;
      S_G_RD:   state_d = S_G_UPD;
      S_G_UPD:  state_d = ant_last ? S_G_FLIP : S_G_RD;
      S_G_FLIP: if (ant_last) state_d = S_REPLY;
      S_REPLY:  if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      clr_reply_q <= 1'b0;
      live_q      <= '0;
      ant_i_q     <= '0;
      kept_q      <= '0;
      gen_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // a new reply loads as the old one leaves
      if (state_q == S_REPLY && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready)             out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: clr_cnt_q <= clr_cnt_q + CellAw'(1);
        S_IDLE: begin
          if (acc) begin
            ant_i_q <= '0;
            kept_q  <= '0;
            gen_cnt_q <= live_q;
            if (in_action == ACT_CLEAR) begin
              live_q      <= '0;
              clr_reply_q <= 1'b1;
              clr_cnt_q   <= '0;
            end else if (in_action == ACT_PLACE && !(in_row >= side || in_col >= side)
                         && live_q < AntCntW'(MaxAnts)) begin
              live_q <= live_q + AntCntW'(1);
            end
          end
        end
        S_G_UPD: begin
          if (alive) kept_q <= kept_q + AntCntW'(1);
          ant_i_q <= ant_last ? '0 : ant_i_q + AntIdxW'(1);
        end
        S_G_FLIP: begin
          ant_i_q <= ant_i_q + AntIdxW'(1);
          if (ant_last) live_q <= kept_q;
        end
        default: ;
      endcase
    end
  end

  // payload: ant table, scratch, reply
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          req_row_q <= in_row;
          req_col_q <= in_col;
          for (int k = 0; k < MaxAnts; k++) snap_q[k] <= {ant_row_q[k], ant_col_q[k]};
          res_q <= '0;
          unique case (in_action)
            ACT_PLACE: begin
              if (in_row >= side || in_col >= side) begin
                res_q.status    <= ST_RANGE;
                res_q.live_ants <= live_q;
              end else if (live_q >= AntCntW'(MaxAnts)) begin
                res_q.status    <= ST_FULL;
                res_q.live_ants <= live_q;
              end else begin
                ant_row_q[live_q[AntIdxW-1:0]]  <= in_row;
                ant_col_q[live_q[AntIdxW-1:0]]  <= in_col;
                ant_head_q[live_q[AntIdxW-1:0]] <= in_heading;
                res_q.live_ants <= live_q + AntCntW'(1);
              end
            end
            ACT_RD_CELL: begin
              res_q.live_ants <= live_q;
              if (in_row >= side || in_col >= side) res_q.status <= ST_RANGE;
            end
            ACT_RD_ANT: begin
              res_q.live_ants <= live_q;
              if ({1'b0, in_index} >= live_q) begin
                res_q.status <= ST_INDEX;
              end else begin
                res_q.ant_row     <= ant_row_q[in_index];
                res_q.ant_col     <= ant_col_q[in_index];
                res_q.ant_heading <= ant_head_q[in_index];
              end
            end
            ACT_CLEAR: ;
            default:   res_q.live_ants <= live_q;
          endcase
        end
      end
      S_CELL_D: res_q.cell_black <= rd_data_q;
      S_G_UPD: begin
        flip_q[ant_i_q]  <= first_here && flip_wanted(policy_q, touches);
        color_q[ant_i_q] <= rd_data_q;
        if (alive) begin
          ant_row_q[kept_q[AntIdxW-1:0]]  <= nrow[CoordW-1:0];
          ant_col_q[kept_q[AntIdxW-1:0]]  <= ncol[CoordW-1:0];
          ant_head_q[kept_q[AntIdxW-1:0]] <= new_head;
        end
      end
      S_G_FLIP: if (ant_last) res_q.live_ants <= kept_q;
      S_REPLY:  if (out_free) out_q <= res_q;
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.live_ants, out_q.ant_heading, out_q.ant_col,
                          out_q.ant_row, out_q.cell_black, out_q.status};

endmodule

FILE: rtl/core/malg_checker.sv
// Port-level checker for the multi-ant Langton generation engine.
// Depends on malg_pkg; bound to multi_ant_langton_generation below.
module malg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [malg_pkg::OutDataW-1:0] m_axis_tdata
);
  import malg_pkg::*;

  // a pending reply is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("reply dropped or changed while stalled");

  // one request at a time: busy right after a request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // live count never exceeds the table
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[21:17] <= 5'(MaxAnts))
    else $error("live count out of range");

  // bad index reply carries no ant
  a_index_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_INDEX |-> m_axis_tdata[16:3] == '0)
    else $error("ant fields set on bad index");

endmodule

bind multi_ant_langton_generation malg_checker u_malg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: test/tb.sv
// Testbench for multi_ant_langton_generation: a directed table, then random requests.
// Each reply is compared with a behavioral model of the grid and ant table kept here.
// Depends on malg_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb;
  import malg_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // action[2:0], row[8:3], col[14:9], heading[16:15], ant_index[20:17]
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // status[1:0], cell_black[2], ant_row[8:3], ant_col[14:9],
  // ant_heading[16:15], live_ants[21:17]
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  multi_ant_langton_generation u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  typedef struct packed {
    logic [3:0] ant_index;
    logic [1:0] heading;
    logic [5:0] col;
    logic [5:0] row;
    logic [2:0] action;
  } req_t;

  typedef struct packed {
    logic [4:0] live_ants;
    logic [1:0] ant_heading;
    logic [5:0] ant_col;
    logic [5:0] ant_row;
    logic       cell_black;
    logic [1:0] status;
  } rsp_t;

  // Model state: grid, ant table, live count, registers.
  logic [GridMax*GridMax-1:0] grid_q;
  logic [5:0]  ant_row_q [MaxAnts];
  logic [5:0]  ant_col_q [MaxAnts];
  logic [1:0]  ant_hd_q  [MaxAnts];
  int unsigned live_q;
  logic [6:0]  side_reg;
  logic        torus_reg;
  logic [1:0]  policy_reg;

  rsp_t expected_q[$];
  int   fail_cnt;
  bit   idle_en;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned side_now();
    if (side_reg == 0) return 1;
    if (side_reg > GridMax) return GridMax;
    return side_reg;
  endfunction

  function automatic bit flip_for(int unsigned t);
    if (policy_reg == POL_SINGLE) return t == 1;
    if (policy_reg == POL_ANY) return t > 0;
    return t[0];
  endfunction

  // One generation: turn on start-of-generation color, count touches, move,
  // compact survivors, then flip touched cells the policy selects.
  task automatic advance_generation();
    int unsigned touches [GridMax*GridMax];
    int unsigned n, kept, at;
    logic [6:0]  r, c;
    logic [1:0]  h;
    bit          under, alive;
    n = side_now();
    kept = 0;
    foreach (touches[k]) touches[k] = 0;
    for (int i = 0; i < live_q; i++) begin
      r = {1'b0, ant_row_q[i]};
      c = {1'b0, ant_col_q[i]};
      at = r * GridMax + c;
      h = grid_q[at] ? ant_hd_q[i] - 2'd1 : ant_hd_q[i] + 2'd1;
      touches[at]++;
      under = 0;
      alive = 1;
      case (h)
        2'd0: if (r == 0) under = 1; else r--;
        2'd1: c++;
        2'd2: r++;
        default: if (c == 0) under = 1; else c--;
      endcase
      if (torus_reg) begin
        if (under && h == 2'd0) r = 7'(n - 1);
        else if (r >= n) r = '0;
        if (under && h == 2'd3) c = 7'(n - 1);
        else if (c >= n) c = '0;
      end else if (under || r >= n || c >= n) begin
        alive = 0;
      end
      if (alive) begin
        ant_row_q[kept] = r[5:0];
        ant_col_q[kept] = c[5:0];
        ant_hd_q[kept]  = h;
        kept++;
      end
    end
    foreach (touches[k]) if (touches[k] != 0 && flip_for(touches[k])) grid_q[k] = ~grid_q[k];
    live_q = kept;
  endtask

  function automatic rsp_t predict_reply(req_t q);
    rsp_t o;
    int unsigned n;
    o = '0;
    n = side_now();
    case (q.action)
      ACT_PLACE: begin
        if (q.row >= n || q.col >= n) o.status = ST_RANGE;
        else if (live_q >= MaxAnts) o.status = ST_FULL;
        else begin
          ant_row_q[live_q] = q.row;
          ant_col_q[live_q] = q.col;
          ant_hd_q[live_q]  = q.heading;
          live_q++;
        end
      end
      ACT_RD_CELL: begin
        if (q.row >= n || q.col >= n) o.status = ST_RANGE;
        else o.cell_black = grid_q[q.row * GridMax + q.col];
      end
      ACT_RD_ANT: begin
        if (q.ant_index >= live_q) o.status = ST_INDEX;
        else begin
          o.ant_row = ant_row_q[q.ant_index];
          o.ant_col = ant_col_q[q.ant_index];
          o.ant_heading = ant_hd_q[q.ant_index];
        end
      end
      ACT_CLEAR: begin
        grid_q = '0;
        live_q = 0;
      end
      default: ;
    endcase
    o.live_ants = live_q[4:0];
    return o;
  endfunction

  // Send one request; model updates at acceptance (generation handled here
  // since it is a task). tvalid stays high into the next request unless idling.
  task automatic send_request(req_t q, bit typed, rsp_t typed_rsp);
    rsp_t p;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(q);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (q.action == ACT_GEN) advance_generation();
    p = predict_reply(q);
    if (typed && p != typed_rsp) begin
      $error("table row disagrees with model: row %h model %h", typed_rsp, p);
      fail_cnt++;
    end
    expected_q.insert(expected_q.size(), p);
    @(negedge clk_i);
  endtask

  // Reply checker with random back-pressure.
  initial begin
    rsp_t got, exp;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = rsp_t'(m_axis_tdata[21:0]);
        if (expected_q.size() == 0) begin
          $error("reply with nothing pending: %h", got);
          fail_cnt++;
        end else begin
          exp = expected_q.pop_front();
          if (got.status != exp.status) begin
            $error("status exp %0d got %0d", exp.status, got.status); fail_cnt++;
          end
          if (got.cell_black != exp.cell_black) begin
            $error("cell_black exp %0d got %0d", exp.cell_black, got.cell_black); fail_cnt++;
          end
          if (got.ant_row != exp.ant_row) begin
            $error("ant_row exp %0d got %0d", exp.ant_row, got.ant_row); fail_cnt++;
          end
          if (got.ant_col != exp.ant_col) begin
            $error("ant_col exp %0d got %0d", exp.ant_col, got.ant_col); fail_cnt++;
          end
          if (got.ant_heading != exp.ant_heading) begin
            $error("ant_heading exp %0d got %0d", exp.ant_heading, got.ant_heading);
            fail_cnt++;
          end
          if (got.live_ants != exp.live_ants) begin
            $error("live_ants exp %0d got %0d", exp.live_ants, got.live_ants); fail_cnt++;
          end
        end
      end
    end
  end

  // Register writes only with nothing pending.
  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataW'(val);
    case (idx)
      CFG_GRID_SIZE: side_reg = val[6:0];
      CFG_TORUS:     torus_reg = val[0];
      default:       policy_reg = val[1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic req_t mk(action_e a, int r, int c, int h, int k);
    req_t q;
    q.action = a; q.row = 6'(r); q.col = 6'(c); q.heading = 2'(h); q.ant_index = 4'(k);
    return q;
  endfunction

  function automatic rsp_t rs(status_e s, int live);
    rsp_t o;
    o = '0; o.status = s; o.live_ants = 5'(live);
    return o;
  endfunction

  // Random request, mostly well formed: places in range, generations, reads.
  function automatic req_t random_request();
    req_t q;
    int unsigned n, pick;
    n = side_now();
    q = req_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) q.action = ACT_PLACE;
    else if (pick < 60) q.action = ACT_GEN;
    else if (pick < 80) q.action = ACT_RD_CELL;
    else if (pick < 93) q.action = ACT_RD_ANT;
    else if (pick < 95) q.action = ACT_CLEAR;
    else q.action = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) != 0) begin
      q.row = 6'($urandom_range(0, n - 1));
      q.col = 6'($urandom_range(0, n - 1));
    end
    return q;
  endfunction

  typedef struct {
    req_t q;
    bit   typed;
    rsp_t r;
  } row_t;

  initial begin
    row_t dir_tbl[$];
    int   sizes[6];
    int   pol;
    fail_cnt = 0;
    idle_en = 1;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    grid_q = '0;
    live_q = 0;
    side_reg = 7'd64; torus_reg = 1'b1; policy_reg = POL_ODD;
    foreach (ant_row_q[i]) begin
      ant_row_q[i] = '0; ant_col_q[i] = '0; ant_hd_q[i] = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: extremes, every action, status codes, unknown action.
    dir_tbl = '{
      '{mk(ACT_RD_CELL, 0, 0, 0, 0),   1, rs(ST_OK, 0)},
      '{mk(ACT_RD_CELL, 63, 63, 0, 0), 1, rs(ST_OK, 0)},
      '{mk(ACT_RD_ANT, 0, 0, 0, 0),    1, rs(ST_INDEX, 0)},
      '{mk(ACT_PLACE, 0, 0, 0, 0),     1, rs(ST_OK, 1)},
      '{mk(ACT_PLACE, 63, 63, 3, 15),  1, rs(ST_OK, 2)},
      '{mk(ACT_PLACE, 0, 63, 1, 0),    1, rs(ST_OK, 3)},
      '{mk(ACT_PLACE, 63, 0, 2, 0),    1, rs(ST_OK, 4)},
      '{mk(ACT_RD_ANT, 0, 0, 0, 1),    0, '0},
      '{mk(ACT_RD_ANT, 0, 0, 0, 15),   1, rs(ST_INDEX, 4)},
      '{mk(ACT_GEN, 0, 0, 0, 0),       0, '0},
      '{mk(ACT_RD_ANT, 0, 0, 0, 0),    0, '0},
      '{mk(ACT_RD_CELL, 0, 0, 0, 0),   0, '0},
      '{mk(ACT_GEN, 0, 0, 0, 0),       0, '0},
      '{mk(ACT_RD_CELL, 63, 63, 0, 0), 0, '0},
      '{mk(action_e'(3'd7), 63, 63, 3, 15), 1, rs(ST_OK, 4)},
      '{mk(action_e'(3'd5), 0, 0, 0, 0), 1, rs(ST_OK, 4)},
      '{mk(ACT_CLEAR, 0, 0, 0, 0),     1, rs(ST_OK, 0)},
      '{mk(ACT_RD_CELL, 0, 0, 0, 0),   1, rs(ST_OK, 0)}
    };
    foreach (dir_tbl[i]) send_request(dir_tbl[i].q, dir_tbl[i].typed, dir_tbl[i].r);
    // fill the table, then one more: full
    for (int i = 0; i < MaxAnts; i++) send_request(mk(ACT_PLACE, 5, 5, i, 0), 0, '0);
    send_request(mk(ACT_PLACE, 1, 1, 0, 0), 1, rs(ST_FULL, 16));
    send_request(mk(ACT_GEN, 0, 0, 0, 0), 0, '0);

    // shrink grid with ants outside it; range checks come before full check
    write_reg(CFG_GRID_SIZE, 4);
    write_reg(CFG_TORUS, 0);
    send_request(mk(ACT_PLACE, 4, 0, 0, 0), 0, '0);
    send_request(mk(ACT_RD_CELL, 0, 4, 0, 0), 0, '0);
    send_request(mk(ACT_GEN, 0, 0, 0, 0), 0, '0);
    write_reg(CFG_GRID_SIZE, 0);
    write_reg(CFG_TORUS, 1);
    send_request(mk(ACT_CLEAR, 0, 0, 0, 0), 0, '0);
    send_request(mk(ACT_PLACE, 0, 0, 0, 0), 0, '0);
    send_request(mk(ACT_GEN, 0, 0, 0, 0), 0, '0);
    write_reg(CFG_GRID_SIZE, 127);
    send_request(mk(ACT_PLACE, 63, 63, 2, 0), 0, '0);
    send_request(mk(ACT_GEN, 0, 0, 0, 0), 0, '0);

    // Random phases over sizes, wrap modes and flip policies (policy 3 too).
    sizes = '{1, 2, 3, 5, 8, 64};
    for (int ph = 0; ph < 12; ph++) begin
      pol = ph % 4;
      write_reg(CFG_GRID_SIZE, sizes[ph % 6]);
      write_reg(CFG_TORUS, ph[2]);
      write_reg(CFG_POLICY, pol);
      if (ph == 11) idle_en = 0;
      // bunch ants on a small grid so policies see multiple touches
      send_request(mk(ACT_CLEAR, 0, 0, 0, 0), 0, '0);
      for (int i = 0; i < 33; i++) send_request(random_request(), 0, '0);
    end

    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
